// ===== rtl/mst_pkg.sv =====
// Package for the MRU shadow table cache: payload types, codes and cell control.
`timescale 1ns / 1ps

package mst_pkg;

    // Default configuration
    localparam int NUM_SHADOWS_DEF = 4;
    localparam int FRAME_BITS_DEF  = 40;

    // Fixed field widths
    localparam int ROOT_W   = 40;
    localparam int DOMAIN_W = 16;
    localparam int ENTRY_W  = 9;
    localparam int SLOT_W   = 2;

    typedef enum logic [1:0] {
        ACT_SWITCH = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_RSVD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OUT_NONE  = 3'd0,
        OUT_HIT   = 3'd1,
        OUT_MISS  = 3'd2,
        OUT_SYNC  = 3'd3,
        OUT_DROP  = 3'd4,
        OUT_FAULT = 3'd5
    } outcome_t;

    // Input beat
    typedef struct packed {
        logic [1:0]          action;
        logic [DOMAIN_W-1:0] domain_id;
        logic                need_shadow;
        logic [ROOT_W-1:0]   root_frame;
        logic [ENTRY_W-1:0]  entry_slot;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [2:0]         outcome;
        logic [SLOT_W-1:0]  shadow_slot;
        logic [ENTRY_W-1:0] sync_entry;
    } res_t;

    // What a cell loads at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LEFT  = 2'd1,
        CELL_RIGHT = 2'd2,
        CELL_NEW   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     zero;   // force the loaded frame to free
    } cell_ctrl_t;

endpackage

// ===== rtl/mst_cell.sv =====
// One entry of the MRU chain: frame tag, bound shadow slot and tag compare.
`timescale 1ns / 1ps

module mst_cell #(
    parameter int FRAME_BITS = 40,
    parameter int SLOT_BITS  = 2,
    parameter int RESET_SLOT = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mst_pkg::cell_ctrl_t    ctrl,
    input  logic [FRAME_BITS-1:0]  key,
    input  logic [SLOT_BITS-1:0]   ins_slot,
    input  logic [FRAME_BITS-1:0]  left_frame,
    input  logic [SLOT_BITS-1:0]   left_slot,
    input  logic [FRAME_BITS-1:0]  right_frame,
    input  logic [SLOT_BITS-1:0]   right_slot,
    output logic [FRAME_BITS-1:0]  frame,
    output logic [SLOT_BITS-1:0]   slot,
    output logic                   match
);
    import mst_pkg::*;

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;

    // Next entry contents
    always_comb
    begin
        frame_next = frame_reg;
        slot_next  = slot_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                frame_next = frame_reg;
                slot_next  = slot_reg;
            end
            CELL_LEFT:
            begin
                frame_next = left_frame;
                slot_next  = left_slot;
            end
            CELL_RIGHT:
            begin
                frame_next = right_frame;
                slot_next  = right_slot;
            end
            CELL_NEW:
            begin
                frame_next = key;
                slot_next  = ins_slot;
            end
        endcase
        if (ctrl.zero)
        begin
            frame_next = '0;
        end
    end

    // Entry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            slot_reg  <= SLOT_BITS'(RESET_SLOT);
        end
        else
        begin
            frame_reg <= frame_next;
            slot_reg  <= slot_next;
        end
    end

    // A free entry never hits
    assign match = (frame_reg != '0) && (frame_reg == key);
    assign frame = frame_reg;
    assign slot  = slot_reg;

endmodule

// ===== rtl/mru_shadow_table_cache_unit.sv =====
// Top level of the MRU shadow table cache: decode, chain of entry cells, result register.
//
//   channel | ports                  | handshake
//   --------+------------------------+-------------------------------------------
//   command | start, busy, cmd       | beat taken at an edge with start=1, busy=0
//   result  | done, result           | beat shown for one cycle, done=1
//
// One command every cycle; busy is never raised. The chain of cells is compared
// and shifted in the cycle the command is taken, so the next command sees the
// updated order. Each result appears on result with done in the cycle after its
// command is taken. Reset frees every entry, binds slots 0..N-1 in order and
// clears the owner. The receiver cannot stall results.
`timescale 1ns / 1ps

module mru_shadow_table_cache_unit #(
    parameter int NUM_SHADOWS = mst_pkg::NUM_SHADOWS_DEF,
    parameter int FRAME_BITS  = mst_pkg::FRAME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mst_pkg::cmd_t cmd,
    output logic          done,
    output mst_pkg::res_t result
);
    import mst_pkg::*;

    localparam int SB = $clog2(NUM_SHADOWS);
    localparam logic [SB-1:0] LAST = SB'(NUM_SHADOWS - 1);

    // Chain wiring
    logic [FRAME_BITS-1:0] cell_frame [NUM_SHADOWS];
    logic [SB-1:0]         cell_slot  [NUM_SHADOWS];
    logic [NUM_SHADOWS-1:0] cell_match;
    cell_ctrl_t            cell_ctrl  [NUM_SHADOWS];
    logic [SB-1:0]         ins_slot;

    // Owner and result registers
    logic [DOMAIN_W-1:0] owner_domain_reg, owner_domain_next;
    logic                owner_valid_reg, owner_valid_next;
    logic                done_reg;
    res_t                result_reg, result_next;

    // Command decode helpers
    logic [FRAME_BITS+ROOT_W-1:0] key_wide;
    logic [FRAME_BITS-1:0]        key;
    logic                         is_switch, flush, owned, hit;
    logic [SB-1:0]                pos;
    logic [SB-1:0]                hit_slot;
    logic [SB+1:0]                slot_wide;

    assign key_wide = {{FRAME_BITS{1'b0}}, cmd.root_frame};
    assign key      = key_wide[FRAME_BITS-1:0];

    // Row of entry cells
    for (genvar g = 0; g < NUM_SHADOWS; g++)
    begin : g_cell
        logic [FRAME_BITS-1:0] lf, rf;
        logic [SB-1:0]         ls, rs;
        if (g == 0)
        begin : g_head
            assign lf = '0;
            assign ls = '0;
        end
        else
        begin : g_mid_l
            assign lf = cell_frame[g-1];
            assign ls = cell_slot[g-1];
        end
        if (g == NUM_SHADOWS - 1)
        begin : g_tail
            assign rf = '0;
            assign rs = '0;
        end
        else
        begin : g_mid_r
            assign rf = cell_frame[g+1];
            assign rs = cell_slot[g+1];
        end

        mst_cell #(
            .FRAME_BITS (FRAME_BITS),
            .SLOT_BITS  (SB),
            .RESET_SLOT (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl[g]),
            .key         (key),
            .ins_slot    (ins_slot),
            .left_frame  (lf),
            .left_slot   (ls),
            .right_frame (rf),
            .right_slot  (rs),
            .frame       (cell_frame[g]),
            .slot        (cell_slot[g]),
            .match       (cell_match[g])
        );
    end

    // Hit position: at most one entry holds a given frame
    always_comb
    begin
        pos      = '0;
        hit_slot = '0;
        for (int i = NUM_SHADOWS - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                pos      = SB'(i);
                hit_slot = cell_slot[i];
            end
        end
    end

    assign is_switch = (cmd.action == ACT_SWITCH);
    assign flush     = is_switch && owner_valid_reg && (owner_domain_reg != cmd.domain_id);
    assign owned     = owner_valid_reg && (owner_domain_reg == cmd.domain_id);
    assign hit       = (|cell_match) && !flush;

    // Cell control, owner update and result
    always_comb
    begin
        owner_domain_next = owner_domain_reg;
        owner_valid_next  = owner_valid_reg;
        ins_slot          = '0;
        slot_wide         = '0;
        result_next       = '0;
        result_next.outcome = OUT_NONE;
        for (int i = 0; i < NUM_SHADOWS; i++)
        begin
            cell_ctrl[i].op   = CELL_HOLD;
            cell_ctrl[i].zero = 1'b0;
        end

        if (start)
        begin
            priority if (is_switch)
            begin
                if (flush)
                begin
                    owner_valid_next = 1'b0;
                end
                if (!cmd.need_shadow)
                begin
                    // drop frames on a domain change, otherwise untouched
                    for (int i = 0; i < NUM_SHADOWS; i++)
                    begin
                        cell_ctrl[i].zero = flush;
                    end
                end
                else
                begin
                    owner_domain_next = cmd.domain_id;
                    owner_valid_next  = 1'b1;
                    if (hit)
                    begin
                        // rotate the hit entry to the front
                        ins_slot = hit_slot;
                        for (int i = 0; i < NUM_SHADOWS; i++)
                        begin
                            if (i == 0)
                            begin
                                cell_ctrl[i].op = CELL_NEW;
                            end
                            else if (SB'(i) <= pos)
                            begin
                                cell_ctrl[i].op = CELL_LEFT;
                            end
                        end
                        result_next.outcome = OUT_HIT;
                    end
                    else
                    begin
                        // recycle the last slot, shift the whole row back
                        ins_slot = cell_slot[NUM_SHADOWS-1];
                        for (int i = 0; i < NUM_SHADOWS; i++)
                        begin
                            if (i == 0)
                            begin
                                cell_ctrl[i].op = CELL_NEW;
                            end
                            else
                            begin
                                cell_ctrl[i].op   = CELL_LEFT;
                                cell_ctrl[i].zero = flush;
                            end
                        end
                        result_next.outcome = OUT_MISS;
                    end
                    slot_wide = {2'b00, ins_slot};
                    result_next.shadow_slot = slot_wide[1:0];
                end
            end
            else if (cmd.action != ACT_RSVD && cmd.need_shadow && owned && hit)
            begin
                if (cmd.action == ACT_WRITE)
                begin
                    slot_wide = {2'b00, hit_slot};
                    result_next.outcome     = OUT_SYNC;
                    result_next.shadow_slot = slot_wide[1:0];
                    result_next.sync_entry  = cmd.entry_slot;
                end
                else if (pos == '0)
                begin
                    result_next.outcome = OUT_FAULT;
                end
                else
                begin
                    // demote to the tail and free it
                    ins_slot = hit_slot;
                    for (int i = 0; i < NUM_SHADOWS; i++)
                    begin
                        if (i == NUM_SHADOWS - 1)
                        begin
                            cell_ctrl[i].op   = CELL_NEW;
                            cell_ctrl[i].zero = 1'b1;
                        end
                        else if (SB'(i) >= pos)
                        begin
                            cell_ctrl[i].op = CELL_RIGHT;
                        end
                    end
                    slot_wide = {2'b00, hit_slot};
                    result_next.outcome     = OUT_DROP;
                    result_next.shadow_slot = slot_wide[1:0];
                end
            end
            else
            begin
                result_next.outcome = OUT_NONE;
            end
        end
        if (pos > LAST)
        begin
            result_next.outcome = OUT_NONE;
        end
    end

    // Owner and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_domain_reg <= '0;
            owner_valid_reg  <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            owner_domain_reg <= owner_domain_next;
            owner_valid_reg  <= owner_valid_next;
            done_reg         <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== test/mst_cache_checker.sv =====
// Checker for the MRU shadow table cache: predicts each result beat and compares it.
`timescale 1ns / 1ps

module mst_cache_checker #(
    parameter int NUM_SHADOWS = mst_pkg::NUM_SHADOWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  mst_pkg::cmd_t cmd,
    input  logic          done,
    input  mst_pkg::res_t result,
    output int            errors,
    output int            outstanding
);
    import mst_pkg::*;

    // Shadow copy of the cache: order list, slot bindings and owner
    logic [ROOT_W-1:0]   order_frame [NUM_SHADOWS];
    logic [SLOT_W-1:0]   order_slot  [NUM_SHADOWS];
    logic [DOMAIN_W-1:0] owner_dom;
    logic                owner_ok;

    // Results still to arrive, oldest first
    res_t pending_results [$];

    // Position of the live entry holding a frame, -1 when absent
    function automatic int frame_position(input logic [ROOT_W-1:0] f);
        for (int i = 0; i < NUM_SHADOWS; i++)
        begin
            if (order_frame[i] != '0 && order_frame[i] == f)
                return i;
        end
        return -1;
    endfunction

    // Apply one command beat to the shadow copy and return its result
    function automatic res_t resolve_cmd(input cmd_t c);
        res_t              r;
        int                pos;
        logic [ROOT_W-1:0] tf;
        logic [SLOT_W-1:0] ts;
        r = '0;
        if (c.action == ACT_SWITCH)
        begin
            // switching to another domain flushes every entry first
            if (owner_ok && owner_dom != c.domain_id)
            begin
                owner_ok = 1'b0;
                for (int i = 0; i < NUM_SHADOWS; i++)
                    order_frame[i] = '0;
            end
            if (!c.need_shadow)
                return r;
            owner_dom = c.domain_id;
            owner_ok  = 1'b1;
            pos = frame_position(c.root_frame);
            if (pos >= 0)
            begin
                // hit: move the entry to the front
                tf = order_frame[pos];
                ts = order_slot[pos];
                for (int i = pos; i > 0; i--)
                begin
                    order_frame[i] = order_frame[i-1];
                    order_slot[i]  = order_slot[i-1];
                end
                r.outcome = OUT_HIT;
            end
            else
            begin
                // miss: recycle the last slot for the new frame
                tf = c.root_frame;
                ts = order_slot[NUM_SHADOWS-1];
                for (int i = NUM_SHADOWS - 1; i > 0; i--)
                begin
                    order_frame[i] = order_frame[i-1];
                    order_slot[i]  = order_slot[i-1];
                end
                r.outcome = OUT_MISS;
            end
            order_frame[0] = tf;
            order_slot[0]  = ts;
            r.shadow_slot  = ts;
            return r;
        end

        // notices only count for the owner, with shadowing, on a cached frame
        if (c.action == ACT_RSVD || !c.need_shadow || !owner_ok || owner_dom != c.domain_id)
            return r;
        pos = frame_position(c.root_frame);
        if (pos < 0)
            return r;
        if (c.action == ACT_WRITE)
        begin
            r.outcome     = OUT_SYNC;
            r.shadow_slot = order_slot[pos];
            r.sync_entry  = c.entry_slot;
            return r;
        end
        if (pos == 0)
        begin
            r.outcome = OUT_FAULT;
            return r;
        end
        // free: demote to the back and release the frame
        ts = order_slot[pos];
        for (int i = pos; i < NUM_SHADOWS - 1; i++)
        begin
            order_frame[i] = order_frame[i+1];
            order_slot[i]  = order_slot[i+1];
        end
        order_frame[NUM_SHADOWS-1] = '0;
        order_slot[NUM_SHADOWS-1]  = ts;
        r.outcome     = OUT_DROP;
        r.shadow_slot = ts;
        return r;
    endfunction

    // Watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        int   bad;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SHADOWS; i++)
            begin
                order_frame[i] = '0;
                order_slot[i]  = SLOT_W'(i);
            end
            owner_dom = '0;
            owner_ok  = 1'b0;
            pending_results.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (start && !busy)
                pending_results.push_back(resolve_cmd(cmd));
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    bad++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, result.outcome);
                        bad++;
                    end
                    if (result.shadow_slot !== want.shadow_slot)
                    begin
                        $error("shadow_slot: expected %0d, got %0d",
                               want.shadow_slot, result.shadow_slot);
                        bad++;
                    end
                    if (result.sync_entry !== want.sync_entry)
                    begin
                        $error("sync_entry: expected %0d, got %0d",
                               want.sync_entry, result.sync_entry);
                        bad++;
                    end
                end
            end
            errors      <= errors + bad;
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== test/tb_mru_shadow_table_cache_unit.sv =====
// Testbench top for the MRU shadow table cache: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_mru_shadow_table_cache_unit;
    import mst_pkg::*;

    localparam int POOL_SIZE   = 6;
    localparam int RAND_BEATS  = 125;   // per idling phase
    localparam int DRAIN_LIMIT = 1000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    res_t result;
    int   errors;
    int   outstanding;

    // Current session: owning domain and the frames it tends to use
    logic [DOMAIN_W-1:0] session_dom;
    logic [ROOT_W-1:0]   frame_pool [POOL_SIZE];
    int                  idle_pct;

    mru_shadow_table_cache_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    mst_cache_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs or results go missing
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic cmd_t make_cmd(input action_t a, input logic [DOMAIN_W-1:0] d,
                                      input logic n, input logic [ROOT_W-1:0] f,
                                      input logic [ENTRY_W-1:0] e);
        cmd_t c;
        c.action      = a;
        c.domain_id   = d;
        c.need_shadow = n;
        c.root_frame  = f;
        c.entry_slot  = e;
        return c;
    endfunction

    function automatic logic [ROOT_W-1:0] rand_frame();
        logic [ROOT_W-1:0] f;
        f = ROOT_W'({$urandom, $urandom});
        return (f == '0) ? ROOT_W'(1) : f;
    endfunction

    task automatic new_session(input logic [DOMAIN_W-1:0] d);
        session_dom = d;
        for (int i = 0; i < POOL_SIZE; i++)
            frame_pool[i] = rand_frame();
    endtask

    // Offer one beat, idling first at the current rate
    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic from the session owner, with some noise
    task automatic send_random();
        int                  pick;
        int                  fpick;
        action_t             a;
        logic [DOMAIN_W-1:0] d;
        logic                n;
        logic [ROOT_W-1:0]   f;
        pick  = $urandom_range(99);
        fpick = $urandom_range(99);
        d     = ($urandom_range(99) < 92) ? session_dom : DOMAIN_W'($urandom);
        n     = ($urandom_range(99) < 95);
        if (fpick < 85)
            f = frame_pool[$urandom_range(POOL_SIZE - 1)];
        else if (fpick < 97)
            f = rand_frame();
        else
            f = '0;
        if (pick < 45)
            a = ACT_SWITCH;
        else if (pick < 72)
            a = ACT_WRITE;
        else if (pick < 92)
            a = ACT_FREE;
        else if (pick < 95)
            a = ACT_RSVD;
        else
        begin
            a = action_t'($urandom_range(3));
            n = 1'b0;
        end
        // a shadowed switch to another domain moves the session there, half the time with new frames
        if (a == ACT_SWITCH && n && d != session_dom)
        begin
            if ($urandom_range(1) == 0)
                new_session(d);
            else
                session_dom = d;
        end
        send_cmd(make_cmd(a, d, n, f, ENTRY_W'($urandom)));
    endtask

    initial
    begin
        logic [ROOT_W-1:0] f_max;
        logic [ROOT_W-1:0] f_a;
        logic [ROOT_W-1:0] f_b;
        int                waited;
        f_max = '1;
        f_a   = rand_frame();
        f_b   = rand_frame();
        idle_pct = 0;
        new_session(16'h1234);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats
        send_cmd(make_cmd(ACT_WRITE,  16'h0000, 1'b1, f_max,       9'd5));   // no owner yet
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b0, f_max,       9'd0));   // unshadowed
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, f_max,       9'd0));   // miss
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, ROOT_W'(1),  9'd0));   // miss
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, f_a,         9'd0));   // miss
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, f_b,         9'd0));   // miss, full
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, ROOT_W'(1),  9'd0));   // hit, to front
        send_cmd(make_cmd(ACT_WRITE,  16'h0000, 1'b1, f_max,       9'd511)); // sync
        send_cmd(make_cmd(ACT_WRITE,  16'h0000, 1'b1, ROOT_W'(1),  9'd0));   // sync
        send_cmd(make_cmd(ACT_FREE,   16'h0000, 1'b1, ROOT_W'(1),  9'd0));   // front: fault
        send_cmd(make_cmd(ACT_FREE,   16'h0000, 1'b1, f_max,       9'd0));   // dropped
        send_cmd(make_cmd(ACT_WRITE,  16'h0000, 1'b1, f_max,       9'd3));   // freed, unknown
        send_cmd(make_cmd(ACT_WRITE,  16'h0000, 1'b0, f_a,         9'd3));   // no shadowing
        send_cmd(make_cmd(ACT_FREE,   16'hFFFF, 1'b1, f_a,         9'd0));   // foreign domain
        send_cmd(make_cmd(ACT_RSVD,   16'h0000, 1'b1, f_a,         9'd511)); // reserved action
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, '0,          9'd0));   // zero frame
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, '0,          9'd0));   // zero never hits
        send_cmd(make_cmd(ACT_SWITCH, 16'hFFFF, 1'b0, f_a,         9'd0));   // flush, unshadowed
        send_cmd(make_cmd(ACT_WRITE,  16'hFFFF, 1'b1, f_a,         9'd1));   // owner gone
        send_cmd(make_cmd(ACT_SWITCH, 16'hFFFF, 1'b1, f_a,         9'd0));   // miss after flush
        send_cmd(make_cmd(ACT_SWITCH, 16'h0000, 1'b1, f_a,         9'd0));   // flush and miss

        // Random beats across the idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 54;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            for (int k = 0; k < RAND_BEATS; k++)
                send_random();
        end
        start <= 1'b0;

        // Drain, then allow for the result latency
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (8) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mst_pkg.sv
rtl/mst_cell.sv
rtl/mru_shadow_table_cache_unit.sv
test/mst_cache_checker.sv
test/tb_mru_shadow_table_cache_unit.sv
